FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files; only rank_assigner_top includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define RA_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/ra_pkg.sv
`default_nettype none
package ra_pkg;

  localparam int MAX_COUNT = 64;
  localparam int IDX_W     = $clog2(MAX_COUNT);
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int VALUE_W   = 32;
  localparam int RANK_W    = 6;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_value;
  } ra_in_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              last_rank;
  } ra_out_t;

  typedef struct packed {
    logic store;
    logic rank_init;
    logic rd_i;
    logic cap_i;
    logic sweep;
    logic emit;
  } ra_cmd_t;

  typedef struct packed {
    logic last_j;
    logic last_i;
    logic out_free;
  } ra_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rank_assigner_top.sv
//  Channel   Direction  Handshake          Request fields
//  in_       input      in_valid/in_ready  value, last_value
//  out_      output     out_valid/out_ready rank, last_rank
//
//  Values are accepted one a cycle while the controller is idle, and stored while there is room.
//  After the flagged request, each stored value is ranked in turn: it is read and captured,
//  then all entries are swept past one comparator through the single memory read port,
//  and the count of smaller entries is emitted as its rank.
//  Reset (rst_n low, synchronous) empties the store; out_ready stalls only the emit step.
`default_nettype none
`include "assert_macros.svh"
module rank_assigner_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ra_pkg::ra_in_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ra_pkg::ra_out_t     out_data
);
  import ra_pkg::*;

  ra_cmd_t cmd;
  ra_sts_t sts;

  ra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_value),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ra_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `RA_ASSERT(a_emit_free, clk, rst_n, cmd.emit |-> sts.out_free, "Result overwritten")
  `RA_ASSERT(a_last_starts, clk, rst_n, (in_valid && in_ready && in_data.last_value) |=> !in_ready, "Ranking did not start")
  `RA_NEVER(a_store_busy, clk, rst_n, cmd.store && (cmd.sweep || cmd.emit), "Store while ranking")

endmodule
`default_nettype wire

FILE: hw/rtl/ra_datapath.sv
`default_nettype none
module ra_datapath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ra_pkg::ra_in_t in_data,
  input  wire ra_pkg::ra_cmd_t cmd,
  output ra_pkg::ra_sts_t     sts,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ra_pkg::ra_out_t     out_data
);
  import ra_pkg::*;

  logic signed [VALUE_W-1:0] mem [MAX_COUNT];
  logic signed [VALUE_W-1:0] rdata_r;
  logic signed [VALUE_W-1:0] vi_r, vi_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [IDX_W-1:0]          i_r, i_nxt;
  logic [IDX_W-1:0]          j_r, j_nxt;
  logic [CNT_W-1:0]          smaller_r, smaller_nxt;
  logic                      cmp_v_r, cmp_v_nxt;
  logic                      out_valid_r, out_valid_nxt;
  ra_out_t                   out_data_r, out_data_nxt;
  logic [IDX_W-1:0]          rd_addr;
  logic                      room;
  logic [CNT_W-1:0]          last_idx;

  assign room     = count_r < CNT_W'(MAX_COUNT);
  assign last_idx = count_r - CNT_W'(1);
  assign rd_addr  = cmd.rd_i ? i_r : j_r;

  assign sts.last_j   = {{(CNT_W-IDX_W){1'b0}}, j_r} == last_idx;
  assign sts.last_i   = {{(CNT_W-IDX_W){1'b0}}, i_r} == last_idx;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.store && room) begin
      mem[count_r[IDX_W-1:0]] <= in_data.value;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt     = count_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    vi_nxt        = vi_r;
    smaller_nxt   = smaller_r;
    cmp_v_nxt     = cmd.sweep;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.store && room) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.rank_init) begin
      i_nxt = '0;
    end
    if (cmd.cap_i) begin
      vi_nxt      = rdata_r;
      j_nxt       = '0;
      smaller_nxt = '0;
    end else if (cmp_v_r && (rdata_r < vi_r)) begin
      smaller_nxt = smaller_r + CNT_W'(1);
    end
    if (cmd.sweep) begin
      j_nxt = j_r + IDX_W'(1);
    end
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.rank      = smaller_r[RANK_W-1:0];
      out_data_nxt.last_rank = sts.last_i;
      if (sts.last_i) begin
        count_nxt = '0;
      end else begin
        i_nxt = i_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    vi_r       <= vi_nxt;
    smaller_r  <= smaller_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ra_ctrl.sv
`default_nettype none
module ra_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_last,
  output logic                 in_ready,
  input  wire ra_pkg::ra_sts_t sts,
  output ra_pkg::ra_cmd_t      cmd
);
  import ra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_I,
    S_CAP_I,
    S_SWEEP,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cmd.store     = in_valid && in_ready;
    cmd.rank_init = cmd.store && in_last;
    case (state_r)
      S_IDLE: begin
        if (cmd.rank_init) begin
          state_nxt = S_RD_I;
        end
      end
      S_RD_I: begin
        cmd.rd_i  = 1'b1;
        state_nxt = S_CAP_I;
      end
      S_CAP_I: begin
        cmd.cap_i = 1'b1;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.last_j) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_i ? S_IDLE : S_RD_I;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire
